[rtl/core/qlsf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package qlsf_pkg;

    localparam int SAMPLES = 16;
    localparam int CNT_W   = 7;
    localparam int TIME_W  = 12;
    localparam int DIST_W  = 24;
    localparam int POW_W   = 48;
    localparam int SUM_W   = 56;
    localparam int ENT_W   = 64;
    localparam int WW      = 256;
    localparam int COEF_W  = 48;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 144;

    localparam logic [4:0] OP_NOP     = 5'd0;
    localparam logic [4:0] OP_SLOAD   = 5'd1;
    localparam logic [4:0] OP_SSTEP   = 5'd2;
    localparam logic [4:0] OP_LDMC    = 5'd3;
    localparam logic [4:0] OP_LDMT    = 5'd4;
    localparam logic [4:0] OP_MSTART  = 5'd5;
    localparam logic [4:0] OP_MSTEP   = 5'd6;
    localparam logic [4:0] OP_TSET    = 5'd7;
    localparam logic [4:0] OP_TSUB    = 5'd8;
    localparam logic [4:0] OP_DACC    = 5'd9;
    localparam logic [4:0] OP_DETSET  = 5'd10;
    localparam logic [4:0] OP_DIVST   = 5'd11;
    localparam logic [4:0] OP_DIVSTEP = 5'd12;
    localparam logic [4:0] OP_DIVRND  = 5'd13;
    localparam logic [4:0] OP_DIVEND  = 5'd14;
    localparam logic [4:0] OP_OUT     = 5'd15;

    // flag: clear d on OP_LDMC, last bit on OP_MSTEP, subtract on OP_DACC
    typedef struct packed {
        logic [4:0] op;
        logic [3:0] sel;
        logic [1:0] k;
        logic       flag;
    } t_cmd;

    typedef struct packed {
        logic d_zero;
    } t_status;

endpackage
`default_nettype wire

[rtl/core/qlsf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module qlsf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire qlsf_pkg::t_status i_status,
    output qlsf_pkg::t_cmd       o_cmd
);
    import qlsf_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SAMP = 4'd1;
    localparam logic [3:0] S_LDM  = 4'd2;
    localparam logic [3:0] S_MST  = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_TACC = 4'd5;
    localparam logic [3:0] S_DACC = 4'd6;
    localparam logic [3:0] S_DSEL = 4'd7;
    localparam logic [3:0] S_DIV0 = 4'd8;
    localparam logic [3:0] S_DIVS = 4'd9;
    localparam logic [3:0] S_DIVR = 4'd10;
    localparam logic [3:0] S_DIVE = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0]       r_state, n_state;
    logic [1:0]       r_step, n_step;
    logic [CNT_W-1:0] r_nsamp, n_nsamp;
    logic [1:0]       r_repl, n_repl;
    logic [1:0]       r_j, n_j;
    logic [1:0]       r_ph, n_ph;
    logic [7:0]       r_cnt, n_cnt;
    logic             r_ovalid, n_ovalid;
    logic [1:0]       w_a, w_b;

    // entry index; repl 0 is the plain matrix, repl n puts the rhs in column n-1
    function automatic logic [3:0] f_sel(input logic [1:0] row, input logic [1:0] col,
                                         input logic [1:0] repl);
        logic [1:0] ce;
        ce = (repl != 2'd0 && col == repl - 2'd1) ? 2'd3 : col;
        return {row, ce};
    endfunction

    assign w_a = (r_j == 2'd0) ? 2'd1 : 2'd0;
    assign w_b = (r_j == 2'd2) ? 2'd1 : 2'd2;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_nsamp  = r_nsamp;
        n_repl   = r_repl;
        n_j      = r_j;
        n_ph     = r_ph;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '{op: OP_NOP, sel: 4'd0, k: 2'd0, flag: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_SLOAD;
                    n_step   = 2'd0;
                    n_state  = S_SAMP;
                end
            end
            S_SAMP: begin
                o_cmd.op = OP_SSTEP;
                o_cmd.k  = r_step;
                n_step   = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_nsamp = r_nsamp + CNT_W'(1);
                    if (n_nsamp == CNT_W'(SAMPLES)) begin
                        n_repl  = 2'd0;
                        n_j     = 2'd0;
                        n_ph    = 2'd0;
                        n_state = S_LDM;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LDM: begin
                if (r_ph == 2'd2) begin
                    o_cmd.op = OP_LDMT;
                end else begin
                    o_cmd.op   = OP_LDMC;
                    o_cmd.sel  = f_sel(2'd2, (r_ph == 2'd0) ? w_b : w_a, r_repl);
                    o_cmd.flag = (r_ph == 2'd0) && (r_j == 2'd0);
                end
                n_state = S_MST;
            end
            S_MST: begin
                o_cmd.op = OP_MSTART;
                priority if (r_ph == 2'd0) o_cmd.sel = f_sel(2'd1, w_a, r_repl);
                else if (r_ph == 2'd1)     o_cmd.sel = f_sel(2'd1, w_b, r_repl);
                else                       o_cmd.sel = f_sel(2'd0, r_j, r_repl);
                n_cnt   = 8'd0;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.op   = OP_MSTEP;
                o_cmd.flag = (r_cnt == 8'(ENT_W - 1));
                n_cnt      = r_cnt + 8'd1;
                if (r_cnt == 8'(ENT_W - 1)) n_state = (r_ph == 2'd2) ? S_DACC : S_TACC;
            end
            S_TACC: begin
                o_cmd.op = (r_ph == 2'd0) ? OP_TSET : OP_TSUB;
                n_ph     = r_ph + 2'd1;
                n_state  = S_LDM;
            end
            S_DACC: begin
                o_cmd.op   = OP_DACC;
                o_cmd.flag = (r_j == 2'd1);
                n_ph       = 2'd0;
                if (r_j != 2'd2) begin
                    n_j     = r_j + 2'd1;
                    n_state = S_LDM;
                end else begin
                    n_j     = 2'd0;
                    n_state = (r_repl == 2'd0) ? S_DSEL : S_DIV0;
                end
            end
            S_DSEL: begin
                o_cmd.op = OP_DETSET;
                if (i_status.d_zero) begin
                    n_state = S_OUT;
                end else begin
                    n_repl  = 2'd1;
                    n_state = S_LDM;
                end
            end
            S_DIV0: begin
                o_cmd.op = OP_DIVST;
                o_cmd.k  = r_repl - 2'd1;
                n_cnt    = 8'd0;
                n_state  = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.op = OP_DIVSTEP;
                n_cnt    = r_cnt + 8'd1;
                if (r_cnt == 8'(WW - 1)) n_state = S_DIVR;
            end
            S_DIVR: begin
                o_cmd.op = OP_DIVRND;
                n_state  = S_DIVE;
            end
            S_DIVE: begin
                o_cmd.op = OP_DIVEND;
                o_cmd.k  = r_repl - 2'd1;
                if (r_repl == 2'd3) begin
                    n_state = S_OUT;
                end else begin
                    n_repl  = r_repl + 2'd1;
                    n_state = S_LDM;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.op = OP_OUT;
                    n_ovalid = 1'b1;
                    n_nsamp  = '0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= 2'd0;
            r_nsamp  <= '0;
            r_repl   <= 2'd0;
            r_j      <= 2'd0;
            r_ph     <= 2'd0;
            r_cnt    <= 8'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_nsamp  <= n_nsamp;
            r_repl   <= n_repl;
            r_j      <= n_j;
            r_ph     <= n_ph;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

endmodule
`default_nettype wire

[rtl/core/qlsf_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module qlsf_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire qlsf_pkg::t_cmd                      i_cmd,
    input  wire logic [qlsf_pkg::TIME_W-1:0]         i_time,
    input  wire logic signed [qlsf_pkg::DIST_W-1:0]  i_dist,
    output qlsf_pkg::t_status                        o_status,
    output logic signed [qlsf_pkg::COEF_W-1:0]       o_coef_const,
    output logic signed [qlsf_pkg::COEF_W-1:0]       o_coef_linear,
    output logic signed [qlsf_pkg::COEF_W-1:0]       o_coef_square,
    output logic                                     o_singular
);
    import qlsf_pkg::*;

    localparam logic [COEF_W-1:0] MAG_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [COEF_W-1:0] MAG_MAX = {1'b0, {(COEF_W-1){1'b1}}};

    logic [TIME_W-1:0]        r_tin;
    logic signed [DIST_W-1:0] r_din;
    logic [POW_W-1:0]         r_p;
    logic [SUM_W-1:0]         r_s1, r_s2, r_s3, r_s4;
    logic [SUM_W-1:0]         r_b0, r_b1, r_b2;
    logic [WW-1:0]            r_mcand, r_prod, r_t, r_d, r_det;
    logic [ENT_W-1:0]         r_mplier;
    logic [WW-1:0]            r_num, r_den, r_rem, r_q;
    logic                     r_neg, r_sing;
    logic [COEF_W-1:0]        r_coef [3];
    logic [COEF_W-1:0]        r_oc, r_ol, r_os;
    logic                     r_osing;

    logic [SUM_W-1:0]         w_sum;
    logic [ENT_W-1:0]         w_ent;
    logic [POW_W+TIME_W-1:0]  w_pt;
    logic signed [DIST_W+25-1:0] w_dp;
    logic [SUM_W-1:0]         w_dpx, w_ptx;
    logic [WW-1:0]            w_shd, w_nabs, w_dabs, w_rem2, w_addend;
    logic                     w_ge, w_big;
    logic [COEF_W-1:0]        w_mag, w_res;

    // normal matrix entry built from the sums
    always_comb begin
        unique case (i_cmd.sel)
            4'd0:    w_sum = SUM_W'(SAMPLES);
            4'd1:    w_sum = r_s1;
            4'd2:    w_sum = r_s2;
            4'd3:    w_sum = r_b0;
            4'd4:    w_sum = r_s1;
            4'd5:    w_sum = r_s2;
            4'd6:    w_sum = r_s3;
            4'd7:    w_sum = r_b1;
            4'd8:    w_sum = r_s2;
            4'd9:    w_sum = r_s3;
            4'd10:   w_sum = r_s4;
            4'd11:   w_sum = r_b2;
            default: w_sum = '0;
        endcase
    end
    assign w_ent = {{(ENT_W-SUM_W){w_sum[SUM_W-1]}}, w_sum};

    assign w_pt  = r_p * r_tin;
    assign w_dp  = r_din * $signed({1'b0, r_p[23:0]});
    assign w_dpx = SUM_W'(w_dp);
    assign w_ptx = SUM_W'(w_pt[POW_W-1:0]);

    always_comb begin
        unique case (i_cmd.k)
            2'd0:    w_shd = r_d << 16;
            2'd1:    w_shd = r_d << 24;
            default: w_shd = r_d << 32;
        endcase
    end
    assign w_nabs = w_shd[WW-1] ? -w_shd : w_shd;
    assign w_dabs = r_det[WW-1] ? -r_det : r_det;

    assign w_rem2 = {r_rem[WW-2:0], r_num[WW-1]};
    assign w_ge   = (w_rem2 >= r_den);
    assign w_addend = i_cmd.flag ? -r_mcand : r_mcand;

    assign w_big = |r_q[WW-1:COEF_W-1];
    assign w_mag = w_big ? MAG_MIN : r_q[COEF_W-1:0];
    assign w_res = r_neg ? -w_mag : (w_big ? MAG_MAX : w_mag);

    assign o_status.d_zero = (r_d == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
            r_b0 <= '0;
            r_b1 <= '0;
            r_b2 <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_SLOAD: begin
                    r_tin <= i_time;
                    r_din <= i_dist;
                    r_p   <= POW_W'(1);
                end
                OP_SSTEP: begin
                    r_p <= w_pt[POW_W-1:0];
                    unique case (i_cmd.k)
                        2'd0: begin
                            r_s1 <= r_s1 + w_ptx;
                            r_b0 <= r_b0 + w_dpx;
                        end
                        2'd1: begin
                            r_s2 <= r_s2 + w_ptx;
                            r_b1 <= r_b1 + w_dpx;
                        end
                        2'd2: begin
                            r_s3 <= r_s3 + w_ptx;
                            r_b2 <= r_b2 + w_dpx;
                        end
                        default: r_s4 <= r_s4 + w_ptx;
                    endcase
                end
                OP_LDMC: begin
                    r_mcand <= {{(WW-ENT_W){w_ent[ENT_W-1]}}, w_ent};
                    if (i_cmd.flag) r_d <= '0;
                end
                OP_LDMT: r_mcand <= r_t;
                OP_MSTART: begin
                    r_mplier <= w_ent;
                    r_prod   <= '0;
                end
                OP_MSTEP: begin
                    // top multiplier bit carries negative weight
                    if (r_mplier[0]) r_prod <= r_prod + w_addend;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                end
                OP_TSET: r_t <= r_prod;
                OP_TSUB: r_t <= r_t - r_prod;
                OP_DACC: r_d <= i_cmd.flag ? r_d - r_prod : r_d + r_prod;
                OP_DETSET: begin
                    r_det  <= r_d;
                    r_sing <= (r_d == '0);
                end
                OP_DIVST: begin
                    r_neg <= w_shd[WW-1] ^ r_det[WW-1];
                    r_num <= w_nabs;
                    r_den <= w_dabs;
                    r_rem <= '0;
                    r_q   <= '0;
                end
                OP_DIVSTEP: begin
                    r_num <= r_num << 1;
                    r_rem <= w_ge ? w_rem2 - r_den : w_rem2;
                    r_q   <= {r_q[WW-2:0], w_ge};
                end
                OP_DIVRND: begin
                    // round half away from zero on the magnitude
                    if ({r_rem[WW-2:0], 1'b0} >= r_den) r_q <= r_q + WW'(1);
                end
                OP_DIVEND: r_coef[i_cmd.k] <= w_res;
                OP_OUT: begin
                    r_oc    <= r_sing ? '0 : r_coef[0];
                    r_ol    <= r_sing ? '0 : r_coef[1];
                    r_os    <= r_sing ? '0 : r_coef[2];
                    r_osing <= r_sing;
                    r_s1 <= '0;
                    r_s2 <= '0;
                    r_s3 <= '0;
                    r_s4 <= '0;
                    r_b0 <= '0;
                    r_b1 <= '0;
                    r_b2 <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_coef_const  = r_oc;
    assign o_coef_linear = r_ol;
    assign o_coef_square = r_os;
    assign o_singular    = r_osing;

endmodule
`default_nettype wire

[rtl/core/quadratic_least_squares_fit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Quadratic least-squares fit over batches of SAMPLES (time, distance) samples.
// Input stream: one transfer per sample. Output stream: one transfer per batch
// holding the constant, linear and square coefficients (16, 24, 32 fractional
// bits, saturated) and a singular flag in tuser; singular results carry zeros.
// Each sample is loaded on acceptance, then four steps of the power multiplier
// form time^1..time^4 while a second one forms distance * time^0..time^2.
// After the last sample of a batch the solver forms four 3x3 determinants (only
// the first if it is zero), each from nine 64-step shift-add multiplications of
// 256-bit words; each of the last three is followed by a 256-step restoring
// division with rounding. No input is taken while the solver runs. The result
// sits in an output register; the next batch is accepted while it waits, and a
// later result holds in the solver until the receiver takes the earlier one.
// A synchronous active-low reset empties the batch, clears the sums and
// drops any pending result.
module quadratic_least_squares_fit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [11:0] sample_time, [35:12] sample_distance, [39:36] zero
    input  wire logic [39:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [47:0] coef_const, [95:48] coef_linear, [143:96] coef_square
    output logic [143:0]     o_m_axis_tdata,
    // [0] singular
    output logic             o_m_axis_tuser
);
    import qlsf_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic signed [COEF_W-1:0] w_c0, w_c1, w_c2;

    qlsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    qlsf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_time        (i_s_axis_tdata[TIME_W-1:0]),
        .i_dist        ($signed(i_s_axis_tdata[TIME_W+DIST_W-1:TIME_W])),
        .o_status      (w_status),
        .o_coef_const  (w_c0),
        .o_coef_linear (w_c1),
        .o_coef_square (w_c2),
        .o_singular    (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {w_c2, w_c1, w_c0};

endmodule
`default_nettype wire

[rtl/core/qlsf_check.sv]
`timescale 1ns / 1ps
`default_nettype none
module qlsf_check (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [143:0] o_m_axis_tdata,
    input wire logic         o_m_axis_tuser
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output data changed while stalled");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("singular result with non-zero coefficients");

    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("sample accepted while previous one still in work");

endmodule

bind quadratic_least_squares_fit qlsf_check u_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire
